// ===== hdl/sibh_pkg.sv =====
// Shared types and constants for the shift-invariant board hash.
// Used by the modular multiplier, the datapath, the controller and the top level.
`default_nettype none

package sibh_pkg;

  localparam int HW        = 30;   // hash width, values below HMOD
  localparam int BOX_W     = 7;    // bounding box edge width
  localparam int COORD_W   = 6;    // input coordinate width
  localparam int MUL_CNT_W = 5;    // bit counter of the serial multiplier

  localparam logic [HW-1:0] HMOD    = 30'd1000000007;
  localparam logic [HW-1:0] INV_EXP = 30'd1000000005;  // Fermat exponent
  localparam logic [MUL_CNT_W-1:0] INV_LAST_BIT = 5'd29;
  localparam logic [1:0] INV_LAST_IDX = 2'd3;

  localparam logic [HW-1:0] BASE_X0 = 30'd234810943;
  localparam logic [HW-1:0] BASE_X1 = 30'd313566263;
  localparam logic [HW-1:0] BASE_Y0 = 30'd684903403;
  localparam logic [HW-1:0] BASE_Y1 = 30'd395415197;

  localparam logic [1:0] MODE_PLACE  = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;

  localparam logic AX_X = 1'b0;
  localparam logic AX_Y = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_INV_LOAD,
    OP_INV_START,
    OP_INV_TAKE,
    OP_INV_STORE,
    OP_LATCH,
    OP_PUSH,
    OP_POP,
    OP_POP_LOAD,
    OP_CNT_READ,
    OP_CNT_WRITE,
    OP_SET_STEPS,
    OP_SET_MIN,
    OP_SCALE_START,
    OP_SCALE_TAKE
  } dp_op_t;

  typedef enum logic [2:0] {
    TOP_NOP,
    TOP_TERM_ONE,
    TOP_TERM_START,
    TOP_TERM_TAKE,
    TOP_ADD,
    TOP_SUB
  } term_op_t;

  typedef struct packed {
    dp_op_t     op;
    term_op_t   top;      // term and accumulate commands
    logic       axis;     // AX_X column, AX_Y row
    logic       use_inv;  // scale by inverse base
    logic       rel;      // steps = coord - min when set, min - coord otherwise
    logic       scan;     // address / advance the box edge
    logic       dec;      // count write decrements
    logic [1:0] inv_idx;  // {is_y, color}
  } dp_cmd_t;

  typedef struct packed {
    logic       depth_zero;
    logic       depth_full;
    logic [1:0] lt;        // coord below edge, per axis
    logic [1:0] eq;        // coord on edge, per axis
    logic [1:0] min_span;  // edge at empty value, per axis
    logic       steps_zero;
    logic       cnt_zero;
    logic       lane_done;
    logic       inv_last;
    logic       clr_last;
  } dp_status_t;

  function automatic logic [HW-1:0] base_of(input logic is_y, input logic color);
    logic [HW-1:0] b;
    if (is_y) begin
      b = color ? BASE_Y1 : BASE_Y0;
    end else begin
      b = color ? BASE_X1 : BASE_X0;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sibh_modmul.sv =====
// Bit-serial modular multiplier, r = a * b mod HMOD, one bit of b per cycle.
// Depends on sibh_pkg for the modulus and widths.
`default_nettype none

module sibh_modmul (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [sibh_pkg::HW-1:0] a,
  input  wire logic [sibh_pkg::HW-1:0] b,
  output logic                         done,
  output logic [sibh_pkg::HW-1:0]      r
);

  localparam int SW = sibh_pkg::HW + 2;
  localparam logic [SW-1:0] P1 = SW'(sibh_pkg::HMOD);
  localparam logic [SW-1:0] P2 = SW'(sibh_pkg::HMOD) << 1;

  logic                          busy;
  logic [sibh_pkg::MUL_CNT_W-1:0] cnt;
  logic [sibh_pkg::HW-1:0]       acc, aq, bq, acc_next;
  logic [SW-1:0]                 t_sum, t_red;

  // acc < P, so 2*acc + a < 3P: at most two subtractions
  always_comb begin
    t_sum = {1'b0, acc, 1'b0} + (bq[sibh_pkg::HW-1] ? {2'b00, aq} : '0);
    if (t_sum >= P2) begin
      t_red = t_sum - P2;
    end else if (t_sum >= P1) begin
      t_red = t_sum - P1;
    end else begin
      t_red = t_sum;
    end
    acc_next = t_red[sibh_pkg::HW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= sibh_pkg::MUL_CNT_W'(sibh_pkg::HW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      aq  <= a;
      bq  <= b;
    end else if (busy) begin
      acc <= acc_next;
      bq  <= bq << 1;
    end
  end

  assign r = acc;

endmodule

`default_nettype wire

// ===== hdl/sibh_datapath.sv =====
// Datapath: hash registers, box edges, count memories, move stack and two
// modular multiplier lanes. Driven by sibh_ctrl commands; uses sibh_pkg, sibh_modmul.
`default_nettype none

module sibh_datapath #(
  parameter int COORD_SPAN  = 64,
  parameter int STACK_DEPTH = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sibh_pkg::dp_cmd_t            cmd,
  input  wire logic                         in_color,
  input  wire logic [sibh_pkg::COORD_W-1:0] in_x,
  input  wire logic [sibh_pkg::COORD_W-1:0] in_y,
  output sibh_pkg::dp_status_t              status,
  output logic [sibh_pkg::HW:0]             hash_sum,
  output logic [sibh_pkg::BOX_W-1:0]        box_x_min,
  output logic [sibh_pkg::BOX_W-1:0]        box_y_min
);

  localparam int HW    = sibh_pkg::HW;
  localparam int BW    = sibh_pkg::BOX_W;
  localparam int IW    = $clog2(COORD_SPAN);
  localparam int DW    = $clog2(STACK_DEPTH + 1);
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int CW    = DW;
  localparam logic [BW-1:0] SPAN = BW'(COORD_SPAN);
  localparam logic [HW:0]   PW   = {1'b0, sibh_pkg::HMOD};

  function automatic logic [IW-1:0] clamp(input logic [sibh_pkg::COORD_W-1:0] v);
    logic [BW-1:0] w;
    w = BW'(v);
    if (w >= SPAN) begin
      w = BW'(COORD_SPAN - 1);
    end
    return w[IW-1:0];
  endfunction

  // state
  logic [HW-1:0]   h0, h1, t, ib;
  logic [HW-1:0]   inv_x0, inv_x1, inv_y0, inv_y1;
  logic [HW-1:0]   ex;
  logic [sibh_pkg::MUL_CNT_W-1:0] ebit;
  logic [BW-1:0]   min_x, min_y, steps;
  logic [IW-1:0]   cx, cy, clr_addr;
  logic            cc;
  logic [DW-1:0]   depth;
  logic [2*IW-1:0] stk_q;
  logic [CW-1:0]   col_q, row_q;

  logic [CW-1:0]   col_mem [COORD_SPAN];
  logic [CW-1:0]   row_mem [COORD_SPAN];
  logic [2*IW-1:0] stack_mem [STACK_DEPTH];

  // lanes
  logic            start0, start1, done0, done1;
  logic [HW-1:0]   a0, b0, a1, b1, r0, r1;

  logic [BW-1:0]   coord_ax, min_ax;
  logic [IW-1:0]   cnt_raddr, cnt_waddr;
  logic [CW-1:0]   cnt_q, cnt_wdata;
  logic            col_we, row_we;
  logic [DW-1:0]   depth_m1;
  logic [HW-1:0]   hsel, f0, f1;
  logic [HW:0]     add_s, sub_s, acc_s;

  assign coord_ax = cmd.axis ? BW'(cy) : BW'(cx);
  assign min_ax   = cmd.axis ? min_y : min_x;
  assign cnt_q    = cmd.axis ? row_q : col_q;
  assign depth_m1 = depth - 1'b1;

  always_comb begin
    f0 = cmd.use_inv ? (cmd.axis ? inv_y0 : inv_x0) : sibh_pkg::base_of(cmd.axis, 1'b0);
    f1 = cmd.use_inv ? (cmd.axis ? inv_y1 : inv_x1) : sibh_pkg::base_of(cmd.axis, 1'b1);
    start0 = 1'b0;
    start1 = 1'b0;
    a0 = h0;
    b0 = f0;
    a1 = h1;
    b1 = f1;
    case (cmd.op)
      sibh_pkg::OP_INV_START: begin
        start0 = 1'b1;
        start1 = 1'b1;
        a0 = t;
        b0 = ib;
        a1 = ib;
        b1 = ib;
      end
      sibh_pkg::OP_SCALE_START: begin
        start0 = 1'b1;
        start1 = 1'b1;
      end
      default: begin
      end
    endcase
    if (cmd.top == sibh_pkg::TOP_TERM_START) begin
      start0 = 1'b1;
      a0 = t;
      b0 = sibh_pkg::base_of(cmd.axis, cc);
    end
  end

  sibh_modmul u_lane0 (
    .clk(clk), .rst(rst), .start(start0), .a(a0), .b(b0), .done(done0), .r(r0)
  );
  sibh_modmul u_lane1 (
    .clk(clk), .rst(rst), .start(start1), .a(a1), .b(b1), .done(done1), .r(r1)
  );

  // modular add / subtract of the term into the selected color
  always_comb begin
    hsel  = cc ? h1 : h0;
    add_s = {1'b0, hsel} + {1'b0, t};
    sub_s = {1'b0, hsel} + (PW - {1'b0, t});
    acc_s = (cmd.top == sibh_pkg::TOP_ADD) ? add_s : sub_s;
    if (acc_s >= PW) begin
      acc_s = acc_s - PW;
    end
  end

  // count memories
  always_comb begin
    cnt_raddr = cmd.scan ? min_ax[IW-1:0] : coord_ax[IW-1:0];
    cnt_waddr = (cmd.op == sibh_pkg::OP_CLEAR) ? clr_addr : coord_ax[IW-1:0];
    cnt_wdata = (cmd.op == sibh_pkg::OP_CLEAR) ? '0 :
                (cmd.dec ? cnt_q - 1'b1 : cnt_q + 1'b1);
    col_we = (cmd.op == sibh_pkg::OP_CLEAR) ||
             ((cmd.op == sibh_pkg::OP_CNT_WRITE) && (cmd.axis == sibh_pkg::AX_X));
    row_we = (cmd.op == sibh_pkg::OP_CLEAR) ||
             ((cmd.op == sibh_pkg::OP_CNT_WRITE) && (cmd.axis == sibh_pkg::AX_Y));
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[cnt_waddr] <= cnt_wdata;
    end
    col_q <= col_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[cnt_waddr] <= cnt_wdata;
    end
    row_q <= row_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == sibh_pkg::OP_PUSH) begin
      stack_mem[depth[SAW-1:0]] <= {cy, cx};
    end
    stk_q <= stack_mem[depth_m1[SAW-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      h0       <= '0;
      h1       <= '0;
      min_x    <= SPAN;
      min_y    <= SPAN;
      depth    <= '0;
      clr_addr <= '0;
    end else begin
      case (cmd.op)
        sibh_pkg::OP_CLEAR: clr_addr <= clr_addr + 1'b1;
        sibh_pkg::OP_PUSH:  depth <= depth + 1'b1;
        sibh_pkg::OP_POP:   depth <= depth_m1;
        sibh_pkg::OP_SET_MIN: begin
          if (cmd.axis) begin
            min_y <= coord_ax;
          end else begin
            min_x <= coord_ax;
          end
        end
        sibh_pkg::OP_SCALE_TAKE: begin
          h0 <= r0;
          h1 <= r1;
          if (cmd.scan) begin
            if (cmd.axis) begin
              min_y <= min_y + 1'b1;
            end else begin
              min_x <= min_x + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      if ((cmd.top == sibh_pkg::TOP_ADD) || (cmd.top == sibh_pkg::TOP_SUB)) begin
        if (cc) begin
          h1 <= acc_s[HW-1:0];
        end else begin
          h0 <= acc_s[HW-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      sibh_pkg::OP_INV_LOAD: begin
        t    <= HW'(1);
        ib   <= sibh_pkg::base_of(cmd.inv_idx[1], cmd.inv_idx[0]);
        ex   <= sibh_pkg::INV_EXP;
        ebit <= '0;
      end
      sibh_pkg::OP_INV_TAKE: begin
        if (ex[0]) begin
          t <= r0;
        end
        ib   <= r1;
        ex   <= ex >> 1;
        ebit <= ebit + 1'b1;
      end
      sibh_pkg::OP_INV_STORE: begin
        case (cmd.inv_idx)
          2'd0:    inv_x0 <= t;
          2'd1:    inv_x1 <= t;
          2'd2:    inv_y0 <= t;
          default: inv_y1 <= t;
        endcase
      end
      sibh_pkg::OP_LATCH: begin
        cc <= in_color;
        cx <= clamp(in_x);
        cy <= clamp(in_y);
      end
      sibh_pkg::OP_POP_LOAD: begin
        cx <= stk_q[IW-1:0];
        cy <= stk_q[2*IW-1:IW];
      end
      sibh_pkg::OP_SET_STEPS: begin
        steps <= cmd.rel ? coord_ax - min_ax : min_ax - coord_ax;
      end
      sibh_pkg::OP_SCALE_TAKE: begin
        if (!cmd.scan) begin
          steps <= steps - 1'b1;
        end
      end
      default: begin
      end
    endcase
    case (cmd.top)
      sibh_pkg::TOP_TERM_ONE: t <= HW'(1);
      sibh_pkg::TOP_TERM_TAKE: begin
        t     <= r0;
        steps <= steps - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.depth_zero = (depth == '0);
    status.depth_full = (depth == DW'(STACK_DEPTH));
    status.lt         = {BW'(cy) < min_y, BW'(cx) < min_x};
    status.eq         = {BW'(cy) == min_y, BW'(cx) == min_x};
    status.min_span   = {min_y == SPAN, min_x == SPAN};
    status.steps_zero = (steps == '0);
    status.cnt_zero   = (cnt_q == '0);
    status.lane_done  = done0;
    status.inv_last   = (ebit == sibh_pkg::INV_LAST_BIT);
    status.clr_last   = (clr_addr == IW'(COORD_SPAN - 1));
  end

  assign hash_sum  = {1'b0, h0} + {1'b0, h1};
  assign box_x_min = min_x;
  assign box_y_min = min_y;

  a_lanes_together: assert property (@(posedge clk) disable iff (rst) done1 |-> done0)
    else $error("multiplier lanes out of step");
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");
  a_hash_reduced: assert property (@(posedge clk) disable iff (rst)
    (h0 < sibh_pkg::HMOD) && (h1 < sibh_pkg::HMOD))
    else $error("hash not reduced");
  a_edge_range: assert property (@(posedge clk) disable iff (rst)
    (min_x <= SPAN) && (min_y <= SPAN))
    else $error("box edge beyond span");

endmodule

`default_nettype wire

// ===== hdl/sibh_ctrl.sv =====
// Controller: sequences reset sweep, inverse setup, place, remove and query
// requests over the datapath. Uses sibh_pkg command and status types.
`default_nettype none

module sibh_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           in_mode,
  input  wire logic                 out_free,
  input  wire sibh_pkg::dp_status_t status,
  output sibh_pkg::dp_cmd_t         cmd,
  output logic                      in_ready,
  output logic                      out_load,
  output logic                      err
);

  typedef enum logic [4:0] {
    S_CLEAR, S_INV_LOAD, S_INV_START, S_INV_WAIT, S_INV_STORE, S_IDLE,
    S_PUSH, S_RSC_CHK, S_RSC_START, S_RSC_WAIT, S_RSC_TEST, S_SET_MIN,
    S_CNT_RD, S_CNT_WR, S_TERM_INIT, S_TSTEPS, S_TCHK, S_TSTART, S_TWAIT,
    S_ACC, S_POP, S_POP_LD, S_DEC_RD, S_DEC_WR, S_SCAN_CHK, S_SCAN_RD,
    S_SCAN_TEST, S_SCAN_START, S_SCAN_WAIT, S_DONE
  } state_t;

  state_t     state, state_next;
  logic       axis, axis_next;
  logic [1:0] mode_q, mode_next;
  logic       err_next;
  logic [1:0] inv_idx, inv_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      axis    <= sibh_pkg::AX_Y;
      mode_q  <= sibh_pkg::MODE_PLACE;
      err     <= 1'b0;
      inv_idx <= '0;
    end else begin
      state   <= state_next;
      axis    <= axis_next;
      mode_q  <= mode_next;
      err     <= err_next;
      inv_idx <= inv_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    axis_next    = axis;
    mode_next    = mode_q;
    err_next     = err;
    inv_idx_next = inv_idx;
    in_ready     = 1'b0;
    out_load     = 1'b0;
    cmd.op       = sibh_pkg::OP_NOP;
    cmd.top      = sibh_pkg::TOP_NOP;
    cmd.axis     = axis;
    cmd.use_inv  = 1'b0;
    cmd.rel      = 1'b0;
    cmd.scan     = 1'b0;
    cmd.dec      = 1'b0;
    cmd.inv_idx  = inv_idx;
    case (state)
      S_CLEAR: begin
        cmd.op = sibh_pkg::OP_CLEAR;
        if (status.clr_last) begin
          state_next = S_INV_LOAD;
        end
      end
      S_INV_LOAD: begin
        cmd.op     = sibh_pkg::OP_INV_LOAD;
        state_next = S_INV_START;
      end
      S_INV_START: begin
        cmd.op     = sibh_pkg::OP_INV_START;
        state_next = S_INV_WAIT;
      end
      S_INV_WAIT: begin
        if (status.lane_done) begin
          cmd.op     = sibh_pkg::OP_INV_TAKE;
          state_next = status.inv_last ? S_INV_STORE : S_INV_START;
        end
      end
      S_INV_STORE: begin
        cmd.op = sibh_pkg::OP_INV_STORE;
        if (inv_idx == sibh_pkg::INV_LAST_IDX) begin
          state_next = S_IDLE;
        end else begin
          inv_idx_next = inv_idx + 1'b1;
          state_next   = S_INV_LOAD;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = sibh_pkg::OP_LATCH;
          mode_next = in_mode;
          err_next  = 1'b0;
          axis_next = sibh_pkg::AX_Y;
          case (in_mode)
            sibh_pkg::MODE_PLACE: begin
              if (status.depth_full) begin
                err_next   = 1'b1;
                state_next = S_DONE;
              end else begin
                state_next = S_PUSH;
              end
            end
            sibh_pkg::MODE_REMOVE: begin
              if (status.depth_zero) begin
                err_next   = 1'b1;
                state_next = S_DONE;
              end else begin
                state_next = S_POP;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_PUSH: begin
        cmd.op     = sibh_pkg::OP_PUSH;
        state_next = S_RSC_CHK;
      end
      S_RSC_CHK: begin
        if (status.lt[axis]) begin
          cmd.op     = sibh_pkg::OP_SET_STEPS;
          state_next = S_RSC_START;
        end else begin
          state_next = S_CNT_RD;
        end
      end
      S_RSC_START: begin
        cmd.op     = sibh_pkg::OP_SCALE_START;
        state_next = S_RSC_WAIT;
      end
      S_RSC_WAIT: begin
        if (status.lane_done) begin
          cmd.op     = sibh_pkg::OP_SCALE_TAKE;
          state_next = S_RSC_TEST;
        end
      end
      S_RSC_TEST: begin
        state_next = status.steps_zero ? S_SET_MIN : S_RSC_START;
      end
      S_SET_MIN: begin
        cmd.op     = sibh_pkg::OP_SET_MIN;
        state_next = S_CNT_RD;
      end
      S_CNT_RD: begin
        cmd.op     = sibh_pkg::OP_CNT_READ;
        state_next = S_CNT_WR;
      end
      S_CNT_WR: begin
        cmd.op = sibh_pkg::OP_CNT_WRITE;
        if (axis == sibh_pkg::AX_Y) begin
          axis_next  = sibh_pkg::AX_X;
          state_next = S_RSC_CHK;
        end else begin
          state_next = S_TERM_INIT;
        end
      end
      S_TERM_INIT: begin
        cmd.top    = sibh_pkg::TOP_TERM_ONE;
        axis_next  = sibh_pkg::AX_X;
        state_next = S_TSTEPS;
      end
      S_TSTEPS: begin
        cmd.op     = sibh_pkg::OP_SET_STEPS;
        cmd.rel    = 1'b1;
        state_next = S_TCHK;
      end
      S_TCHK: begin
        if (!status.steps_zero) begin
          state_next = S_TSTART;
        end else if (axis == sibh_pkg::AX_X) begin
          axis_next  = sibh_pkg::AX_Y;
          state_next = S_TSTEPS;
        end else begin
          state_next = S_ACC;
        end
      end
      S_TSTART: begin
        cmd.top    = sibh_pkg::TOP_TERM_START;
        state_next = S_TWAIT;
      end
      S_TWAIT: begin
        if (status.lane_done) begin
          cmd.top    = sibh_pkg::TOP_TERM_TAKE;
          state_next = S_TCHK;
        end
      end
      S_ACC: begin
        if (mode_q == sibh_pkg::MODE_PLACE) begin
          cmd.top    = sibh_pkg::TOP_ADD;
          state_next = S_DONE;
        end else begin
          cmd.top    = sibh_pkg::TOP_SUB;
          axis_next  = sibh_pkg::AX_Y;
          state_next = S_DEC_RD;
        end
      end
      S_POP: begin
        cmd.op     = sibh_pkg::OP_POP;
        state_next = S_POP_LD;
      end
      S_POP_LD: begin
        cmd.op     = sibh_pkg::OP_POP_LOAD;
        state_next = S_TERM_INIT;
      end
      S_DEC_RD: begin
        cmd.op     = sibh_pkg::OP_CNT_READ;
        state_next = S_DEC_WR;
      end
      S_DEC_WR: begin
        cmd.op     = sibh_pkg::OP_CNT_WRITE;
        cmd.dec    = 1'b1;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK, S_SCAN_RD, S_SCAN_TEST: begin
        // advance the edge only while it sits on an empty line
        if ((state == S_SCAN_CHK) && status.eq[axis]) begin
          state_next = S_SCAN_RD;
        end else if ((state == S_SCAN_RD) && !status.min_span[axis]) begin
          cmd.op     = sibh_pkg::OP_CNT_READ;
          cmd.scan   = 1'b1;
          state_next = S_SCAN_TEST;
        end else if ((state == S_SCAN_TEST) && status.cnt_zero) begin
          state_next = S_SCAN_START;
        end else if (axis == sibh_pkg::AX_Y) begin
          axis_next  = sibh_pkg::AX_X;
          state_next = S_DEC_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN_START: begin
        cmd.op      = sibh_pkg::OP_SCALE_START;
        cmd.use_inv = 1'b1;
        state_next  = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        cmd.use_inv = 1'b1;
        if (status.lane_done) begin
          cmd.op     = sibh_pkg::OP_SCALE_TAKE;
          cmd.scan   = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (state == S_DONE))
    else $error("result loaded outside completion");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("accepted request did not leave idle");
  a_err_only_done: assert property (@(posedge clk) disable iff (rst)
    (err && (state != S_DONE) && (state != S_IDLE)) |-> 1'b0)
    else $error("error flag set on a request that is executing");

endmodule

`default_nettype wire

// ===== hdl/shift_invariant_board_hash_core.sv =====
// Shift-invariant two-color board hash. One request at a time. Each modular multiply
// is bit-serial and holds the sequencer: a start, then the bit steps that end in a
// handoff. The next request can be accepted in the cycle after the one that loads
// the result. A place pushes the stone, lowers each box edge it lies below by
// rescaling the hash once per unit, bumps the counts, then multiplies out its term
// once per unit of dx and dy and adds it. A remove pops the stone, builds and
// subtracts its term the same way, lowers the counts, and for each edge the stone
// sat on skips empty rows or columns until one is in use or the edge runs out to
// the empty value. A query or a stack error goes straight to the result. dx and dy
// are the stone's offsets from the box corner. A result still held in the output
// register stalls the result load. After reset the block is not ready until it has
// cleared the count memories and derived the four base inverses.
// Depends on sibh_pkg, sibh_ctrl, sibh_datapath, sibh_modmul.
`default_nettype none

module shift_invariant_board_hash_core #(
  parameter int COORD_SPAN  = 64,
  parameter int STACK_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // color[0], x_coord[6:1], y_coord[12:7]
  input  wire logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // hash_sum[30:0], box_x_min[37:31], box_y_min[44:38]
  output logic             m_axis_tuser    // stack_error
);

  sibh_pkg::dp_cmd_t    cmd;
  sibh_pkg::dp_status_t status;
  logic                 out_load, err, out_free;
  logic [sibh_pkg::HW:0]        hash_sum;
  logic [sibh_pkg::BOX_W-1:0]   box_x_min, box_y_min;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  sibh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd),
    .in_ready (s_axis_tready),
    .out_load (out_load),
    .err      (err)
  );

  sibh_datapath #(
    .COORD_SPAN  (COORD_SPAN),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_color  (s_axis_tdata[0]),
    .in_x      (s_axis_tdata[6:1]),
    .in_y      (s_axis_tdata[12:7]),
    .status    (status),
    .hash_sum  (hash_sum),
    .box_x_min (box_x_min),
    .box_y_min (box_y_min)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {3'b000, box_y_min, box_x_min, hash_sum};
      m_axis_tuser <= err;
    end
  end

endmodule

`default_nettype wire
